// ----- design/cdd_pkg.sv -----
`timescale 1ns / 1ps

package cdd_pkg;

   localparam int PC_W    = 5;
   localparam int ROM_D   = 1 << PC_W;
   localparam int N_W     = 19;   // cnt*10 tops out at 327670

   // reciprocal of 25 for |year| <= 32768: q = (x * RECIP25) >> RECIP_SH
   localparam int RECIP25  = 5243;
   localparam int RECIP_SH = 17;
   localparam int PROD_W   = 29;
   localparam int Q_W      = 11;

   // unit selector codes
   localparam logic [2:0] KIND_DAY    = 3'd0;
   localparam logic [2:0] KIND_WEEK   = 3'd1;
   localparam logic [2:0] KIND_MONTH  = 3'd2;
   localparam logic [2:0] KIND_YEAR   = 3'd3;
   localparam logic [2:0] KIND_DECADE = 3'd4;
   localparam logic [2:0] KIND_CENT   = 3'd5;
   localparam logic [2:0] KIND_MILL   = 3'd6;

   localparam logic [3:0] MON_JAN = 4'd1;
   localparam logic [3:0] MON_FEB = 4'd2;
   localparam logic [3:0] MON_DEC = 4'd12;

   // microprogram entry points
   localparam logic [PC_W-1:0] ST_IDLE     = 5'd0;
   localparam logic [PC_W-1:0] ST_DONE     = 5'd6;
   localparam logic [PC_W-1:0] ST_DAY_LOOP = 5'd7;
   localparam logic [PC_W-1:0] ST_DAY_TAIL = 5'd12;
   localparam logic [PC_W-1:0] ST_MON_LOOP = 5'd13;
   localparam logic [PC_W-1:0] ST_YEAR     = 5'd18;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,     // capture request, clamp month, form unit count
      OP_LEAPA,    // |year| * 1/25, registered
      OP_LEAPB,    // leap flag from the quotient
      OP_CLAMP,    // day into 1..len
      OP_SUBPREV,  // n -= day, go to previous month
      OP_SETLEN,   // day = len
      OP_SUBN,     // day -= n
      OP_PREVDEC,  // previous month, n -= 1
      OP_YSUB,     // year -= n
      OP_DONE      // issue result
   } op_type;

   typedef enum logic [2:0] {
      CD_NEXT,
      CD_ALWAYS,
      CD_NOSTART,
      CD_KIND_DW,
      CD_KIND_MON,
      CD_KIND_YR,
      CD_N_LT_D,
      CD_N_ZERO
   } cond_type;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } uword_type;

   typedef struct packed {
      logic kind_dw;
      logic kind_mon;
      logic kind_yr;
      logic n_lt_d;
      logic n_zero;
   } dp_flags_type;

   function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
      logic [4:0] len;
      case (mon)
         4'd2:    len = leap ? 5'd29 : 5'd28;
         4'd4:    len = 5'd30;
         4'd6:    len = 5'd30;
         4'd9:    len = 5'd30;
         4'd11:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

// ----- design/calendar_date_decrementer_core.sv -----
`timescale 1ns / 1ps
// Channel  Ports                                     Dir  Transfer
// request  start, busy, req_type .. req_start_year   in   start && !busy
// result   rsp_valid, rsp_new_day/month/year         out  rsp_valid, one cycle
//
// One request at a time; a microprogram walks it through the datapath, and every
//   leap decision costs two steps (reciprocal multiply, then compare).
// Year units subtract once and month units step back month by month, each with a
//   leap check; day/week walk month boundaries; busy drops with the strobe.
// Reset (synchronous) parks the step counter at idle and drops the strobe.
// The receiver cannot stall; each result is shown for exactly one cycle.

module calendar_date_decrementer_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_type,
   input  logic [14:0]        req_step_count,
   input  logic [4:0]         req_start_day,
   input  logic [3:0]         req_start_month,
   input  logic signed [15:0] req_start_year,
   output logic               rsp_valid,
   output logic [4:0]         rsp_new_day,
   output logic [3:0]         rsp_new_month,
   output logic signed [15:0] rsp_new_year
);

   // step counter of the microprogram
   logic [cdd_pkg::PC_W-1:0] pc_ff, pc_in;
   cdd_pkg::uword_type       word;
   cdd_pkg::op_type          dp_op;
   cdd_pkg::dp_flags_type    flags;
   logic                     accept;
   logic                     take;

   logic [4:0]               day;
   logic [3:0]               month;
   logic signed [15:0]       year;

   logic                     valid_ff, valid_in;
   logic [4:0]               rday_ff, rday_in;
   logic [3:0]               rmon_ff, rmon_in;
   logic signed [15:0]       ryear_ff, ryear_in;

   cdd_urom u_rom (
      .pc   (pc_ff),
      .word (word)
   );

   assign busy   = (pc_ff != cdd_pkg::ST_IDLE);
   assign accept = start && !busy;
   // the idle step only loads on an actual transfer
   assign dp_op  = (word.op == cdd_pkg::OP_LOAD && !accept) ? cdd_pkg::OP_NOP : word.op;

   cdd_datapath u_dp (
      .clock           (clock),
      .op              (dp_op),
      .req_type        (req_type),
      .req_step_count  (req_step_count),
      .req_start_day   (req_start_day),
      .req_start_month (req_start_month),
      .req_start_year  (req_start_year),
      .flags           (flags),
      .day             (day),
      .month           (month),
      .year            (year)
   );

   // sequencer: conditional jump or fall through
   always_comb begin
      case (word.cond)
         cdd_pkg::CD_NEXT:     take = 1'b0;
         cdd_pkg::CD_ALWAYS:   take = 1'b1;
         cdd_pkg::CD_NOSTART:  take = !start;
         cdd_pkg::CD_KIND_DW:  take = flags.kind_dw;
         cdd_pkg::CD_KIND_MON: take = flags.kind_mon;
         cdd_pkg::CD_KIND_YR:  take = flags.kind_yr;
         cdd_pkg::CD_N_LT_D:   take = flags.n_lt_d;
         cdd_pkg::CD_N_ZERO:   take = flags.n_zero;
         default:              take = 1'b1;
      endcase
      pc_in = take ? word.target : pc_ff + cdd_pkg::PC_W'(1);
   end

   // result register: captured on the done step, strobed the cycle after
   always_comb begin
      valid_in = (word.op == cdd_pkg::OP_DONE);
      rday_in  = valid_in ? day : rday_ff;
      rmon_in  = valid_in ? month : rmon_ff;
      ryear_in = valid_in ? year : ryear_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= cdd_pkg::ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         pc_ff    <= pc_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rday_ff  <= rday_in;
      rmon_ff  <= rmon_in;
      ryear_ff <= ryear_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_new_day   = rday_ff;
   assign rsp_new_month = rmon_ff;
   assign rsp_new_year  = ryear_ff;

`ifndef SYNTH
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("transfer did not start the microprogram");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result issued while still busy");

   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_new_day != 5'd0) && (rsp_new_month != 4'd0)
                    && (rsp_new_month <= cdd_pkg::MON_DEC))
      else $error("result date out of range");
`endif

endmodule

// ----- design/cdd_urom.sv -----
`timescale 1ns / 1ps

module cdd_urom (
   input  logic [cdd_pkg::PC_W-1:0] pc,
   output cdd_pkg::uword_type       word
);

   always_comb begin
      case (pc)
         // accept and normalize
         5'd0:  word = '{cdd_pkg::OP_LOAD,    cdd_pkg::CD_NOSTART,  cdd_pkg::ST_IDLE};
         5'd1:  word = '{cdd_pkg::OP_LEAPA,   cdd_pkg::CD_NEXT,     cdd_pkg::ST_IDLE};
         5'd2:  word = '{cdd_pkg::OP_LEAPB,   cdd_pkg::CD_NEXT,     cdd_pkg::ST_IDLE};
         5'd3:  word = '{cdd_pkg::OP_CLAMP,   cdd_pkg::CD_KIND_YR,  cdd_pkg::ST_YEAR};
         5'd4:  word = '{cdd_pkg::OP_NOP,     cdd_pkg::CD_KIND_DW,  cdd_pkg::ST_DAY_LOOP};
         5'd5:  word = '{cdd_pkg::OP_NOP,     cdd_pkg::CD_KIND_MON, cdd_pkg::ST_MON_LOOP};
         5'd6:  word = '{cdd_pkg::OP_DONE,    cdd_pkg::CD_ALWAYS,   cdd_pkg::ST_IDLE};
         // day / week: whole months at a time
         5'd7:  word = '{cdd_pkg::OP_NOP,     cdd_pkg::CD_N_LT_D,   cdd_pkg::ST_DAY_TAIL};
         5'd8:  word = '{cdd_pkg::OP_SUBPREV, cdd_pkg::CD_NEXT,     cdd_pkg::ST_IDLE};
         5'd9:  word = '{cdd_pkg::OP_LEAPA,   cdd_pkg::CD_NEXT,     cdd_pkg::ST_IDLE};
         5'd10: word = '{cdd_pkg::OP_LEAPB,   cdd_pkg::CD_NEXT,     cdd_pkg::ST_IDLE};
         5'd11: word = '{cdd_pkg::OP_SETLEN,  cdd_pkg::CD_ALWAYS,   cdd_pkg::ST_DAY_LOOP};
         5'd12: word = '{cdd_pkg::OP_SUBN,    cdd_pkg::CD_ALWAYS,   cdd_pkg::ST_DONE};
         // month
         5'd13: word = '{cdd_pkg::OP_NOP,     cdd_pkg::CD_N_ZERO,   cdd_pkg::ST_DONE};
         5'd14: word = '{cdd_pkg::OP_PREVDEC, cdd_pkg::CD_NEXT,     cdd_pkg::ST_IDLE};
         5'd15: word = '{cdd_pkg::OP_LEAPA,   cdd_pkg::CD_NEXT,     cdd_pkg::ST_IDLE};
         5'd16: word = '{cdd_pkg::OP_LEAPB,   cdd_pkg::CD_NEXT,     cdd_pkg::ST_IDLE};
         5'd17: word = '{cdd_pkg::OP_CLAMP,   cdd_pkg::CD_ALWAYS,   cdd_pkg::ST_MON_LOOP};
         // year based
         5'd18: word = '{cdd_pkg::OP_YSUB,    cdd_pkg::CD_NEXT,     cdd_pkg::ST_IDLE};
         5'd19: word = '{cdd_pkg::OP_LEAPA,   cdd_pkg::CD_NEXT,     cdd_pkg::ST_IDLE};
         5'd20: word = '{cdd_pkg::OP_LEAPB,   cdd_pkg::CD_NEXT,     cdd_pkg::ST_IDLE};
         5'd21: word = '{cdd_pkg::OP_CLAMP,   cdd_pkg::CD_ALWAYS,   cdd_pkg::ST_DONE};
         default: word = '{cdd_pkg::OP_NOP,   cdd_pkg::CD_ALWAYS,   cdd_pkg::ST_IDLE};
      endcase
   end

endmodule

// ----- design/cdd_datapath.sv -----
`timescale 1ns / 1ps

module cdd_datapath (
   input  logic                  clock,
   input  cdd_pkg::op_type       op,
   input  logic [2:0]            req_type,
   input  logic [14:0]           req_step_count,
   input  logic [4:0]            req_start_day,
   input  logic [3:0]            req_start_month,
   input  logic signed [15:0]    req_start_year,
   output cdd_pkg::dp_flags_type flags,
   output logic [4:0]            day,
   output logic [3:0]            month,
   output logic signed [15:0]    year
);

   logic [2:0]                kind_ff, kind_in;
   logic [cdd_pkg::N_W-1:0]   n_ff, n_in;
   logic [4:0]                day_ff, day_in;
   logic [3:0]                mon_ff, mon_in;
   logic [15:0]               year_ff, year_in;
   logic [cdd_pkg::Q_W-1:0]   q_ff, q_in;
   logic                      leap_ff, leap_in;

   logic [15:0]               abs_year;
   logic [cdd_pkg::PROD_W-1:0] prod;
   logic [15:0]               q25;
   logic                      div25;
   logic [4:0]                len;
   logic [4:0]                day_lo;
   logic [3:0]                prev_mon;
   logic [15:0]               prev_year;
   logic [cdd_pkg::N_W-1:0]   cnt_x;
   logic [cdd_pkg::N_W-1:0]   load_n;
   logic [3:0]                load_mon;

   assign abs_year = year_ff[15] ? (~year_ff + 16'd1) : year_ff;
   assign prod     = cdd_pkg::PROD_W'(abs_year) * cdd_pkg::PROD_W'(cdd_pkg::RECIP25);
   assign q25      = 16'(q_ff) * 16'd25;
   assign div25    = (q25 == abs_year);
   assign len      = cdd_pkg::month_len(mon_ff, leap_ff);
   assign day_lo   = (day_ff == 5'd0) ? 5'd1 : day_ff;
   assign prev_mon  = (mon_ff == cdd_pkg::MON_JAN) ? cdd_pkg::MON_DEC : mon_ff - 4'd1;
   assign prev_year = (mon_ff == cdd_pkg::MON_JAN) ? year_ff - 16'd1 : year_ff;
   assign cnt_x     = cdd_pkg::N_W'(req_step_count);

   always_comb begin
      case (req_type)
         cdd_pkg::KIND_DAY:    load_n = cnt_x;
         cdd_pkg::KIND_WEEK:   load_n = (cnt_x << 3) - cnt_x;
         cdd_pkg::KIND_MONTH:  load_n = cnt_x;
         cdd_pkg::KIND_YEAR:   load_n = cnt_x;
         cdd_pkg::KIND_DECADE: load_n = (cnt_x << 3) + (cnt_x << 1);
         cdd_pkg::KIND_CENT:   load_n = cdd_pkg::N_W'(100);
         cdd_pkg::KIND_MILL:   load_n = cdd_pkg::N_W'(1000);
         default:              load_n = '0;
      endcase
      if (req_start_month == 4'd0)
         load_mon = cdd_pkg::MON_JAN;
      else if (req_start_month > cdd_pkg::MON_DEC)
         load_mon = cdd_pkg::MON_DEC;
      else
         load_mon = req_start_month;
   end

   always_comb begin
      kind_in = kind_ff;
      n_in    = n_ff;
      day_in  = day_ff;
      mon_in  = mon_ff;
      year_in = year_ff;
      q_in    = q_ff;
      leap_in = leap_ff;
      case (op)
         cdd_pkg::OP_LOAD: begin
            kind_in = req_type;
            n_in    = load_n;
            day_in  = req_start_day;
            mon_in  = load_mon;
            year_in = req_start_year;
         end
         cdd_pkg::OP_LEAPA: q_in = prod[cdd_pkg::RECIP_SH +: cdd_pkg::Q_W];
         cdd_pkg::OP_LEAPB:
            leap_in = (year_ff[1:0] == 2'd0) && (!div25 || (year_ff[3:0] == 4'd0));
         cdd_pkg::OP_CLAMP: day_in = (day_lo > len) ? len : day_lo;
         cdd_pkg::OP_SUBPREV: begin
            n_in    = n_ff - cdd_pkg::N_W'(day_ff);
            mon_in  = prev_mon;
            year_in = prev_year;
         end
         cdd_pkg::OP_SETLEN: day_in = len;
         cdd_pkg::OP_SUBN:   day_in = day_ff - n_ff[4:0];
         cdd_pkg::OP_PREVDEC: begin
            n_in    = n_ff - cdd_pkg::N_W'(1);
            mon_in  = prev_mon;
            year_in = prev_year;
         end
         cdd_pkg::OP_YSUB: year_in = year_ff - n_ff[15:0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      n_ff    <= n_in;
      day_ff  <= day_in;
      mon_ff  <= mon_in;
      year_ff <= year_in;
      q_ff    <= q_in;
      leap_ff <= leap_in;
   end

   assign flags.kind_dw  = (kind_ff == cdd_pkg::KIND_DAY) || (kind_ff == cdd_pkg::KIND_WEEK);
   assign flags.kind_mon = (kind_ff == cdd_pkg::KIND_MONTH);
   assign flags.kind_yr  = (kind_ff >= cdd_pkg::KIND_YEAR) && (kind_ff <= cdd_pkg::KIND_MILL);
   assign flags.n_lt_d   = (n_ff < cdd_pkg::N_W'(day_ff));
   assign flags.n_zero   = (n_ff == '0);

   assign day   = day_ff;
   assign month = mon_ff;
   assign year  = signed'(year_ff);

endmodule
